// ===== src/soft_shadow_over_gradient_macros.svh =====
// ----------------------------------------------------------------------------
// soft_shadow_over_gradient assertion macros
// shared concurrent assertion forms for the shadow block
// ----------------------------------------------------------------------------
`ifndef SOFT_SHADOW_OVER_GRADIENT_MACROS_SVH
`define SOFT_SHADOW_OVER_GRADIENT_MACROS_SVH

// same-cycle implication
`define SSOG_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSOG_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ssog_pkg.sv =====
// ----------------------------------------------------------------------------
// ssog_pkg
// constants, register codes and small helpers of the shadow-over-gradient block
// ----------------------------------------------------------------------------
package ssog_pkg;

	typedef enum logic [2:0] {
		REG_BASE_COLOUR  = 3'd0,
		REG_PANEL_HEIGHT = 3'd1,
		REG_COVER_LEFT   = 3'd2,
		REG_COVER_TOP    = 3'd3,
		REG_COVER_WIDTH  = 3'd4,
		REG_COVER_HEIGHT = 3'd5
	} cfg_reg_t;

	localparam int CFG_DATA_WIDTH = 24;
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CHAN_WIDTH     = 8;
	localparam int NUM_CHAN       = 3;

	localparam logic [23:0] BASE_COLOUR_RST = 24'h404040;

	localparam int RAMP_HALF  = 3;
	localparam int OFF_X      = 6;
	localparam int OFF_Y      = 8;
	localparam int PEAK_ALPHA = 147;
	localparam int CHAN_MAX   = 255;

	// m*255/6 for m in 1..5
	function automatic logic [7:0] ramp_lut(input logic [2:0] m);
		logic [7:0] r;
		case (m)
			3'd1: r = 8'd42;
			3'd2: r = 8'd85;
			3'd3: r = 8'd127;
			3'd4: r = 8'd170;
			3'd5: r = 8'd212;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// exact x/255 for x up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
		return s[15:8];
	endfunction

endpackage

// ===== src/ssog_div.sv =====
// ----------------------------------------------------------------------------
// ssog_div
// four-stage restoring divider, two quotient bits per stage, 8-bit quotient
// ----------------------------------------------------------------------------
module ssog_div #(
	parameter int COORD_WIDTH = 12
) (
	input  logic                     clk,
	input  logic [3:0]               en,
	input  logic [COORD_WIDTH+7:0]   dividend,
	input  logic [COORD_WIDTH-1:0]   divisor,
	output logic [7:0]               quotient
);

	localparam int CW = COORD_WIDTH;
	localparam int DW = COORD_WIDTH + 8;

	function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic [CW-1:0] d,
		input int unsigned k);
		logic [DW-1:0] ds;
		ds = DW'(d) << k;
		if (r >= ds) begin
			return {1'b1, r - ds};
		end else begin
			return {1'b0, r};
		end
	endfunction

	logic [DW:0]   t1a, t1b, t2a, t2b, t3a, t3b, t4a, t4b;
	logic [DW-1:0] rem_s1, rem_s2, rem_s3;
	logic [CW-1:0] den_s1, den_s2, den_s3;
	logic [1:0]    quo_s1;
	logic [3:0]    quo_s2;
	logic [5:0]    quo_s3;
	logic [7:0]    quo_s4;

	always_comb begin
		t1a = div_step(dividend, divisor, 7);
		t1b = div_step(t1a[DW-1:0], divisor, 6);
		t2a = div_step(rem_s1, den_s1, 5);
		t2b = div_step(t2a[DW-1:0], den_s1, 4);
		t3a = div_step(rem_s2, den_s2, 3);
		t3b = div_step(t3a[DW-1:0], den_s2, 2);
		t4a = div_step(rem_s3, den_s3, 1);
		t4b = div_step(t4a[DW-1:0], den_s3, 0);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s1 <= t1b[DW-1:0];
			den_s1 <= divisor;
			quo_s1 <= {t1a[DW], t1b[DW]};
		end
		if (en[1]) begin
			rem_s2 <= t2b[DW-1:0];
			den_s2 <= den_s1;
			quo_s2 <= {quo_s1, t2a[DW], t2b[DW]};
		end
		if (en[2]) begin
			rem_s3 <= t3b[DW-1:0];
			den_s3 <= den_s2;
			quo_s3 <= {quo_s2, t3a[DW], t3b[DW]};
		end
		if (en[3]) begin
			quo_s4 <= {quo_s3, t4a[DW], t4b[DW]};
		end
	end

	assign quotient = quo_s4;

endmodule

// ===== src/soft_shadow_over_gradient.sv =====
// ----------------------------------------------------------------------------
// soft_shadow_over_gradient
// pixel colour of a vertical gradient panel darkened by a soft drop shadow
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid / in_ready        pixel_x, pixel_y
//   out      source     out_valid / out_ready      pixel_rgb, shadow_alpha
//   cfg      sink       cfg_wr_en                  cfg_index, cfg_wdata
//
// nine register stages, one pixel per clock unless out_ready stalls, result valid out of stage nine
// the gradient divide by (height - 1) sets the depth: four divider stages
// a stage holds only while it is full and the one after it holds, so bubbles are squeezed out
// asynchronous reset clears the valid bits and loads the register defaults
// ----------------------------------------------------------------------------
`include "soft_shadow_over_gradient_macros.svh"

module soft_shadow_over_gradient #(
	parameter int COORD_WIDTH = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [COORD_WIDTH-1:0]                 pixel_x,
	input  logic [COORD_WIDTH-1:0]                 pixel_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [23:0]                            pixel_rgb,
	output logic [7:0]                             shadow_alpha,
	input  logic                                   cfg_wr_en,
	input  logic [ssog_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
	input  logic [ssog_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata
);

	localparam int CW = COORD_WIDTH;
	localparam int SW = COORD_WIDTH + 3;
	localparam int DW = COORD_WIDTH + 8;
	localparam int NS = 9;

	localparam logic signed [SW-1:0] M_HALF = SW'(ssog_pkg::RAMP_HALF);
	localparam logic signed [SW-1:0] M_FULL = SW'(2 * ssog_pkg::RAMP_HALF);

	function automatic logic [7:0] ramp(input logic signed [SW-1:0] a,
		input logic signed [SW-1:0] b);
		logic signed [SW-1:0] m;
		m = ((a < b) ? a : b) + M_HALF;
		if (m <= 0) begin
			return 8'd0;
		end else if (m >= M_FULL) begin
			return 8'(ssog_pkg::CHAN_MAX);
		end else begin
			return ssog_pkg::ramp_lut(m[2:0]);
		end
	endfunction

	// configuration
	logic [23:0]   base_colour_q;
	logic [CW-1:0] panel_height_q;
	logic [CW-1:0] cover_left_q;
	logic [CW-1:0] cover_top_q;
	logic [CW-1:0] cover_width_q;
	logic [CW-1:0] cover_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_colour_q  <= ssog_pkg::BASE_COLOUR_RST;
			panel_height_q <= CW'(1);
			cover_left_q   <= '0;
			cover_top_q    <= '0;
			cover_width_q  <= '0;
			cover_height_q <= '0;
		end else if (cfg_wr_en) begin
			case (ssog_pkg::cfg_reg_t'(cfg_index))
				ssog_pkg::REG_BASE_COLOUR:  base_colour_q  <= cfg_wdata[23:0];
				ssog_pkg::REG_PANEL_HEIGHT: panel_height_q <= cfg_wdata[CW-1:0];
				ssog_pkg::REG_COVER_LEFT:   cover_left_q   <= cfg_wdata[CW-1:0];
				ssog_pkg::REG_COVER_TOP:    cover_top_q    <= cfg_wdata[CW-1:0];
				ssog_pkg::REG_COVER_WIDTH:  cover_width_q  <= cfg_wdata[CW-1:0];
				ssog_pkg::REG_COVER_HEIGHT: cover_height_q <= cfg_wdata[CW-1:0];
				default: ;
			endcase
		end
	end

	// shadow rectangle bounds
	logic signed [SW-1:0] sx_lo_q, sx_hi_q, sy_lo_q, sy_hi_q;
	logic                 shadow_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_en_q <= 1'b0;
		end else begin
			shadow_en_q <= (|cover_width_q) & (|cover_height_q);
		end
	end

	always_ff @(posedge clk) begin
		sx_lo_q <= SW'(cover_left_q) + SW'(ssog_pkg::OFF_X);
		sx_hi_q <= SW'(cover_left_q) + SW'(cover_width_q) + SW'(ssog_pkg::OFF_X - 1);
		sy_lo_q <= SW'(cover_top_q) + SW'(ssog_pkg::OFF_Y);
		sy_hi_q <= SW'(cover_top_q) + SW'(cover_height_q) + SW'(ssog_pkg::OFF_Y - 1);
	end

	// pipeline flow control
	logic [NS:1] vld_q;
	logic [NS:1] en;

	always_comb begin
		en[NS] = ~vld_q[NS] | out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = ~vld_q[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];

	// stage 1: row clamp
	logic [CW-1:0] hm1;
	logic [CW-1:0] px_s1, py_s1, hm1_s1;

	assign hm1 = (panel_height_q == '0) ? '0 : panel_height_q - CW'(1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			px_s1  <= pixel_x;
			py_s1  <= (pixel_y > hm1) ? hm1 : pixel_y;
			hm1_s1 <= hm1;
		end
	end

	// stage 2: gradient fraction, edge distances
	logic [CW-1:0]        f_s2, n_s2;
	logic signed [SW-1:0] ax_s2, bx_s2, ay_s2, by_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			f_s2  <= (hm1_s1 == '0) ? CW'(1) : hm1_s1 - py_s1;
			n_s2  <= (hm1_s1 == '0) ? CW'(1) : hm1_s1;
			ax_s2 <= SW'(px_s1) - sx_lo_q;
			bx_s2 <= sx_hi_q - SW'(px_s1);
			ay_s2 <= SW'(py_s1) - sy_lo_q;
			by_s2 <= sy_hi_q - SW'(py_s1);
		end
	end

	// stage 3: channel products, ramps
	logic [DW-1:0] prod_s3 [ssog_pkg::NUM_CHAN];
	logic [CW-1:0] n_s3;
	logic [7:0]    rx_s3, ry_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < ssog_pkg::NUM_CHAN; i++) begin
				prod_s3[i] <= DW'(base_colour_q[8*i +: 8]) * DW'(f_s2);
			end
			n_s3  <= n_s2;
			rx_s3 <= shadow_en_q ? ramp(ax_s2, bx_s2) : 8'd0;
			ry_s3 <= shadow_en_q ? ramp(ay_s2, by_s2) : 8'd0;
		end
	end

	// stages 4 to 7: gradient divide
	logic [7:0] quo [ssog_pkg::NUM_CHAN];

	for (genvar i = 0; i < ssog_pkg::NUM_CHAN; i++) begin : g_div
		ssog_div #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_div (
			.clk      (clk),
			.en       (en[7:4]),
			.dividend (prod_s3[i]),
			.divisor  (n_s3),
			.quotient (quo[i])
		);
	end

	// stages 4 to 7: opacity
	logic [7:0]  u_s4, ry_s4, alpha_s6, alpha_s7;
	logic [15:0] v_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			u_s4  <= ssog_pkg::div255(16'(ssog_pkg::PEAK_ALPHA) * 16'(rx_s3));
			ry_s4 <= ry_s3;
		end
		if (en[5]) begin
			v_s5 <= 16'(u_s4) * 16'(ry_s4);
		end
		if (en[6]) begin
			alpha_s6 <= ssog_pkg::div255(v_s5);
		end
		if (en[7]) begin
			alpha_s7 <= alpha_s6;
		end
	end

	// stages 8 and 9: darken
	logic [15:0] mul_s8 [ssog_pkg::NUM_CHAN];
	logic [7:0]  rgb_s9 [ssog_pkg::NUM_CHAN];
	logic [7:0]  alpha_s8, alpha_s9;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			for (int i = 0; i < ssog_pkg::NUM_CHAN; i++) begin
				mul_s8[i] <= 16'(quo[i]) * 16'(8'(ssog_pkg::CHAN_MAX) - alpha_s7);
			end
			alpha_s8 <= alpha_s7;
		end
		if (en[9]) begin
			for (int i = 0; i < ssog_pkg::NUM_CHAN; i++) begin
				rgb_s9[i] <= ssog_pkg::div255(mul_s8[i]);
			end
			alpha_s9 <= alpha_s8;
		end
	end

	assign pixel_rgb    = {rgb_s9[2], rgb_s9[1], rgb_s9[0]};
	assign shadow_alpha = alpha_s9;

	`SSOG_ASSERT_IMP(a_alpha_peak, clk, arst_n, out_valid,
		shadow_alpha <= 8'(ssog_pkg::PEAK_ALPHA), "shadow opacity above peak")
	`SSOG_ASSERT_NXT(a_in_enters, clk, arst_n, in_valid && in_ready,
		vld_q[1], "accepted request not in first stage")
	`SSOG_ASSERT_NXT(a_out_holds, clk, arst_n, out_valid && !out_ready,
		out_valid, "stalled result dropped")
	`SSOG_ASSERT_IMP(a_full_stall, clk, arst_n, !in_ready,
		&vld_q, "input stalled with a free stage")

endmodule
